FILE: rtl/core/bam_pkg.sv
`default_nettype none

package bam_pkg;

   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 6;
   localparam int TOTAL_W = 7;

   // request word: func, block_index
   localparam int REQ_TDATA_W = 8;
   // result word: status, granted_index, block_is_valid, valid_total,
   // map_empty, highest_valid, any_valid, one pad bit
   localparam int RSP_TDATA_W = 24;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_QUERY   = 2'd2
   } func_type;

   typedef enum logic {
      STATUS_DONE = 1'b0,
      STATUS_FULL = 1'b1
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/core/block_allocation_bitmap.sv
// A request is held in the input register, and its result then in the result register.
// Throughput: one request per cycle; a new request stalls only when both the
//   input register and the result register are full and the result is not taken.
// Allocate picks the lowest free block through one priority encoder in that cycle.
// Reset (synchronous, active high) frees every block, zeroes the count and
//   empties both registers.
`default_nettype none

module block_allocation_bitmap #(
   parameter int BLOCK_COUNT = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [1:0] func, [7:2] block_index
   input  wire logic [bam_pkg::REQ_TDATA_W-1:0]    req_tdata,

   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [0] status, [6:1] granted_index, [7] block_is_valid, [14:8] valid_total,
   // [15] map_empty, [21:16] highest_valid, [22] any_valid, [23] zero
   output logic [bam_pkg::RSP_TDATA_W-1:0]         rsp_tdata
);

   localparam int IW    = $clog2(BLOCK_COUNT);
   localparam int CNT_W = $clog2(BLOCK_COUNT + 1);

   // input register
   logic                            req_valid_ff, req_valid_in;
   logic [bam_pkg::FUNC_W-1:0]      req_func_ff;
   logic [bam_pkg::INDEX_W-1:0]     req_index_ff;

   // map state
   logic [BLOCK_COUNT-1:0]          map_ff, map_in;
   logic [CNT_W-1:0]                count_ff, count_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            status_ff, status_in;
   logic [bam_pkg::INDEX_W-1:0]     granted_ff, granted_in;
   logic                            was_valid_ff, was_valid_in;

   logic                            advance;
   logic                            in_range;
   logic [IW-1:0]                   sel;
   logic                            bit_at;
   logic                            free_found;
   logic [IW-1:0]                   free_idx;
   logic                            high_found;
   logic [IW-1:0]                   high_idx;
   logic [bam_pkg::TOTAL_W-1:0]     total;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   assign sel      = IW'(req_index_ff);
   assign in_range = 32'(req_index_ff) < BLOCK_COUNT;
   assign bit_at   = in_range ? map_ff[sel] : 1'b0;

   bam_find #(
      .WIDTH        (BLOCK_COUNT),
      .FIND_HIGHEST (1'b0)
   ) u_free_find (
      .vec   (~map_ff),
      .found (free_found),
      .index (free_idx)
   );

   // map_ff already holds the post-step map of the result on display
   bam_find #(
      .WIDTH        (BLOCK_COUNT),
      .FIND_HIGHEST (1'b1)
   ) u_high_find (
      .vec   (map_ff),
      .found (high_found),
      .index (high_idx)
   );

   always_comb begin
      req_valid_in = (req_tvalid && req_tready) || (req_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

      map_in       = map_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      was_valid_in = was_valid_ff;

      if (advance) begin
         status_in    = bam_pkg::STATUS_DONE;
         granted_in   = '0;
         was_valid_in = 1'b0;
         unique case (bam_pkg::func_type'(req_func_ff))
            bam_pkg::FUNC_ALLOC: begin
               if (free_found) begin
                  map_in[free_idx] = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
                  granted_in       = bam_pkg::INDEX_W'(free_idx);
               end else begin
                  status_in = bam_pkg::STATUS_FULL;
               end
            end
            bam_pkg::FUNC_RELEASE: begin
               if (bit_at) begin
                  map_in[sel] = 1'b0;
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            bam_pkg::FUNC_QUERY: begin
               was_valid_in = bit_at;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         map_ff       <= '0;
         count_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         map_ff       <= map_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_func_ff  <= req_tdata[bam_pkg::FUNC_W-1:0];
         req_index_ff <= req_tdata[bam_pkg::FUNC_W +: bam_pkg::INDEX_W];
      end
      status_ff    <= status_in;
      granted_ff   <= granted_in;
      was_valid_ff <= was_valid_in;
   end

   assign total = (32'(count_ff) > 32'(bam_pkg::TOTAL_MAX)) ? bam_pkg::TOTAL_MAX
                                                           : bam_pkg::TOTAL_W'(count_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0,
                        high_found,
                        bam_pkg::INDEX_W'(high_idx),
                        (count_ff == '0),
                        total,
                        was_valid_ff,
                        granted_ff,
                        status_ff};

endmodule

`default_nettype wire

FILE: rtl/core/bam_find.sv
`default_nettype none

module bam_find #(
   parameter int WIDTH        = 64,
   parameter bit FIND_HIGHEST = 1'b0
) (
   input  wire logic [WIDTH-1:0]         vec,
   output logic                          found,
   output logic [$clog2(WIDTH)-1:0]      index
);

   localparam int IW = $clog2(WIDTH);

   always_comb begin
      found = 1'b0;
      index = '0;
      if (FIND_HIGHEST) begin
         // last hit in ascending order wins
         for (int i = 0; i < WIDTH; i++) begin
            if (vec[i]) begin
               found = 1'b1;
               index = IW'(i);
            end
         end
      end else begin
         for (int i = WIDTH - 1; i >= 0; i--) begin
            if (vec[i]) begin
               found = 1'b1;
               index = IW'(i);
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/bam_checker.sv
`default_nettype none

module bam_checker #(
   parameter int BLOCK_COUNT = 64
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [bam_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int FULL_TOTAL = (BLOCK_COUNT > 127) ? 127 : BLOCK_COUNT;

   logic [bam_pkg::TOTAL_W-1:0] last_total_ff, last_total_in;
   logic                        seen_ff, seen_in;
   logic                        rsp_take;
   logic [bam_pkg::TOTAL_W-1:0] cur_total;

   assign rsp_take  = rsp_tvalid && rsp_tready;
   assign cur_total = rsp_tdata[14:8];

   always_comb begin
      seen_in       = seen_ff || rsp_take;
      last_total_in = rsp_take ? cur_total : last_total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= 1'b0;
         last_total_ff <= '0;
      end else begin
         seen_ff       <= seen_in;
         last_total_ff <= last_total_in;
      end
   end

   // nothing comes out of the result side right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // input register is empty right after reset
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request side not ready after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a failed allocate only happens on a full map
   a_full_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] == bam_pkg::STATUS_FULL
         |-> cur_total == bam_pkg::TOTAL_W'(FULL_TOTAL))
      else $error("allocate failed below full map");

   // one request moves the count by at most one
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && seen_ff |->
         cur_total == last_total_ff ||
         cur_total == last_total_ff + bam_pkg::TOTAL_W'(1) ||
         cur_total == last_total_ff - bam_pkg::TOTAL_W'(1))
      else $error("valid count jumped");

endmodule

bind block_allocation_bitmap bam_checker #(
   .BLOCK_COUNT (BLOCK_COUNT)
) u_bam_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int NUM_BLOCKS = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;
   // func code 3 has no meaning in the block; it must change nothing
   localparam logic [bam_pkg::FUNC_W-1:0] FUNC_UNDEF = 2'd3;

   typedef struct packed {
      bam_pkg::status_type          status;
      logic [bam_pkg::INDEX_W-1:0]  granted;
      logic                         blk_valid;
      logic [bam_pkg::TOTAL_W-1:0]  total;
      logic                         empty;
      logic [bam_pkg::INDEX_W-1:0]  highest;
      logic                         any;
   } map_result_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [bam_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [bam_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // predicted map state, advanced as each request is issued
   logic [NUM_BLOCKS-1:0]  model_map;
   int                     model_count;
   map_result_type         pending_results[$];
   int                     fail_count;
   int                     cycle_count;
   bit                     tx_quiet;

   block_allocation_bitmap #(
      .BLOCK_COUNT(NUM_BLOCKS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int draw_wait(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 10);
   endfunction

   // first-fit allocate, release, query; returns the result the block must give
   function automatic map_result_type apply_map_op(
         input logic [bam_pkg::FUNC_W-1:0] op,
         input logic [bam_pkg::INDEX_W-1:0] blk);
      map_result_type r;
      bit hit;
      r = '0;
      hit = 1'b0;
      case (op)
         bam_pkg::FUNC_ALLOC: begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
               if (!hit && !model_map[i]) begin
                  model_map[i] = 1'b1;
                  model_count++;
                  r.granted = bam_pkg::INDEX_W'(i);
                  hit = 1'b1;
               end
            end
            if (!hit) r.status = bam_pkg::STATUS_FULL;
         end
         bam_pkg::FUNC_RELEASE: begin
            if (blk < NUM_BLOCKS && model_map[blk]) begin
               model_map[blk] = 1'b0;
               if (model_count > 0) model_count--;
            end
         end
         bam_pkg::FUNC_QUERY: begin
            if (blk < NUM_BLOCKS) r.blk_valid = model_map[blk];
         end
         default: ;
      endcase
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         if (model_map[i]) begin
            r.highest = bam_pkg::INDEX_W'(i);
            r.any = 1'b1;
         end
      end
      r.total = (model_count > bam_pkg::TOTAL_MAX) ? bam_pkg::TOTAL_MAX
                                                   : bam_pkg::TOTAL_W'(model_count);
      r.empty = (model_count == 0);
      return r;
   endfunction

   // a valid block from a random starting point, or any index if the map is empty
   function automatic logic [bam_pkg::INDEX_W-1:0] pick_valid_block();
      int start;
      int k;
      start = $urandom_range(0, NUM_BLOCKS - 1);
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         k = (start + i) % NUM_BLOCKS;
         if (model_map[k]) return bam_pkg::INDEX_W'(k);
      end
      return bam_pkg::INDEX_W'($urandom_range(0, NUM_BLOCKS - 1));
   endfunction

   task automatic issue_request(input logic [bam_pkg::FUNC_W-1:0] op,
                                input logic [bam_pkg::INDEX_W-1:0] blk);
      int gap;
      gap = draw_wait(tx_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {blk, op};
      pending_results.push_back(apply_map_op(op, blk));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial begin : result_checker
      int stall;
      bit rx_quiet;
      map_result_type want;
      map_result_type got;
      rx_quiet = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
         stall = draw_wait(rx_quiet);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got.status    = bam_pkg::status_type'(rsp_tdata[0]);
         got.granted   = rsp_tdata[6:1];
         got.blk_valid = rsp_tdata[7];
         got.total     = rsp_tdata[14:8];
         got.empty     = rsp_tdata[15];
         got.highest   = rsp_tdata[21:16];
         got.any       = rsp_tdata[22];
         if (pending_results.size() == 0) begin
            $error("unexpected response, tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, got.status);
            check_field("granted_index", want.granted, got.granted);
            check_field("block_is_valid", want.blk_valid, got.blk_valid);
            check_field("valid_total", want.total, got.total);
            check_field("map_empty", want.empty, got.empty);
            check_field("highest_valid", want.highest, got.highest);
            check_field("any_valid", want.any, got.any);
         end
      end
   end

   task automatic test_basic_ops();
      tx_quiet = 1'b0;
      issue_request(bam_pkg::FUNC_QUERY, 6'd0);
      issue_request(bam_pkg::FUNC_QUERY, 6'd63);
      issue_request(bam_pkg::FUNC_RELEASE, 6'd0);      // releasing a free block is a no-op
      issue_request(bam_pkg::FUNC_RELEASE, 6'd63);
      issue_request(FUNC_UNDEF, 6'd63);
      issue_request(bam_pkg::FUNC_ALLOC, 6'd63);       // index ignored by allocate
      issue_request(bam_pkg::FUNC_ALLOC, 6'd0);
      issue_request(bam_pkg::FUNC_ALLOC, 6'd21);
      issue_request(bam_pkg::FUNC_QUERY, 6'd1);
      issue_request(bam_pkg::FUNC_QUERY, 6'd63);
      issue_request(bam_pkg::FUNC_RELEASE, 6'd1);
      issue_request(bam_pkg::FUNC_QUERY, 6'd1);
      issue_request(bam_pkg::FUNC_ALLOC, 6'd0);        // hole at 1 is refilled first
      issue_request(bam_pkg::FUNC_RELEASE, 6'd0);
      issue_request(bam_pkg::FUNC_RELEASE, 6'd0);
      issue_request(FUNC_UNDEF, 6'd0);
      issue_request(bam_pkg::FUNC_RELEASE, 6'd2);
      issue_request(bam_pkg::FUNC_RELEASE, 6'd1);
      issue_request(bam_pkg::FUNC_QUERY, 6'b101010);
      issue_request(bam_pkg::FUNC_QUERY, 6'b010101);
   endtask

   task automatic test_map_full();
      tx_quiet = 1'b1;
      repeat (NUM_BLOCKS) issue_request(bam_pkg::FUNC_ALLOC, bam_pkg::INDEX_W'($urandom));
      tx_quiet = 1'b0;
      repeat (3) issue_request(bam_pkg::FUNC_ALLOC, bam_pkg::INDEX_W'($urandom));
      issue_request(bam_pkg::FUNC_QUERY, 6'd0);
      issue_request(bam_pkg::FUNC_QUERY, 6'd63);
      issue_request(FUNC_UNDEF, 6'd17);
      issue_request(bam_pkg::FUNC_RELEASE, 6'd63);
      issue_request(bam_pkg::FUNC_ALLOC, 6'd0);
      issue_request(bam_pkg::FUNC_ALLOC, 6'd0);
   endtask

   task automatic test_random_mix(input int n_items);
      int alloc_pct;
      int r;
      logic [bam_pkg::INDEX_W-1:0] blk;
      for (int n = 0; n < n_items; n++) begin
         // segments lean toward filling, churning or emptying the map
         if (n % 60 == 0) begin
            case ($urandom_range(0, 2))
               0: alloc_pct = 85;
               1: alloc_pct = 50;
               default: alloc_pct = 15;
            endcase
            tx_quiet = ($urandom_range(0, 3) == 0);
         end
         r = $urandom_range(0, 99);
         blk = ($urandom_range(0, 3) != 0) ?
                  pick_valid_block() :
                  bam_pkg::INDEX_W'($urandom_range(0, NUM_BLOCKS - 1));
         if (r < 3)
            issue_request(FUNC_UNDEF, bam_pkg::INDEX_W'($urandom));
         else if (r < 3 + alloc_pct)
            issue_request(bam_pkg::FUNC_ALLOC, bam_pkg::INDEX_W'($urandom));
         else if ($urandom_range(0, 9) < 6)
            issue_request(bam_pkg::FUNC_RELEASE, blk);
         else
            issue_request(bam_pkg::FUNC_QUERY, ($urandom_range(0, 1) != 0) ? blk
                                               : bam_pkg::INDEX_W'($urandom));
      end
   endtask

   task automatic test_drain();
      tx_quiet = 1'b0;
      while (model_count > 0) issue_request(bam_pkg::FUNC_RELEASE, pick_valid_block());
      issue_request(bam_pkg::FUNC_QUERY, bam_pkg::INDEX_W'($urandom));
      issue_request(bam_pkg::FUNC_RELEASE, bam_pkg::INDEX_W'($urandom));
      issue_request(bam_pkg::FUNC_ALLOC, bam_pkg::INDEX_W'($urandom));
   endtask

   initial begin
      model_map = '0;
      model_count = 0;
      fail_count = 0;
      cycle_count = 0;
      tx_quiet = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_map_full();
      test_random_mix(1000);
      test_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
